// ===== rtl/core/per_beam_temporal_median_core_macros.svh =====
// Assertion macros shared by the per-beam temporal median core.
// No dependencies; included by the top level inside its module body.
`ifndef PER_BEAM_TEMPORAL_MEDIAN_CORE_MACROS_SVH
`define PER_BEAM_TEMPORAL_MEDIAN_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PBTM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define PBTM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define PBTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pbtm_pkg.sv =====
// Shared types and constants of the per-beam temporal median core.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package pbtm_pkg;

    localparam int BEAM_W      = 10;
    localparam int FIELD_W     = 16;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int TDATA_W     = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 4'd3;
    localparam logic             TRAILING_MODE_RST = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'd0,
        CFG_TRAILING_MODE = 1'd1
    } t_cfg_idx;

    // Classification of one accepted word, made by the front end.
    typedef struct packed {
        logic [BEAM_W-1:0] beam_index;
        logic              in_range;
        logic              emit;
        logic              last;
    } t_item_ctl;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic clearing;
        logic cmd_pop;
    } t_back_stat;

    typedef struct packed {
        logic               last_of_scan;
        logic [FIELD_W-1:0] median_intensity;
        logic [FIELD_W-1:0] median_range;
        logic [BEAM_W-1:0]  out_beam_index;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/pbtm_fifo.sv =====
// Small register-based first-word-fall-through queue.
// Standalone; used for the command queue and the result queue.
`default_nettype none

module pbtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic      [CNT_W-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/pbtm_front.sv =====
// Front end: configuration registers, scan slot tracking and item classification.
// Depends on pbtm_pkg.
`default_nettype none

module pbtm_front #(
    parameter int WINDOW_MAX = 8,
    parameter int MAX_BEAMS  = 1024,
    parameter int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int LEN_W      = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pbtm_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [pbtm_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                             i_valid,
    input  wire logic                             i_hold,
    input  wire logic [pbtm_pkg::BEAM_W-1:0]      i_beam,
    input  wire logic                             i_eos,
    output logic                                  o_ready,
    output logic                                  o_push,
    output pbtm_pkg::t_item_ctl                   o_ctl,
    output logic      [SLOT_W-1:0]                o_slot,
    output logic      [LEN_W-1:0]                 o_len
);

    import pbtm_pkg::*;

    logic [CFG_W-1:0]  r_win_len;
    logic              r_trailing;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_slot_cur;
    logic [LEN_W-1:0]  w_slot_inc;
    logic              w_accept;

    always_comb begin
        if (r_win_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_win_len) > 32'(WINDOW_MAX)) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = LEN_W'(r_win_len);
        end

        // A slot left beyond a shrunken window restarts at the first slot.
        w_slot_cur = (LEN_W'(r_slot) >= w_len) ? '0 : LEN_W'(r_slot);
        w_slot_inc = w_slot_cur + 1'b1;

        o_ready  = !i_hold;
        w_accept = i_valid && o_ready;
        o_push   = w_accept;

        o_ctl.beam_index = i_beam;
        o_ctl.in_range   = 32'(i_beam) < 32'(MAX_BEAMS);
        o_ctl.emit       = r_trailing || (w_slot_cur == w_len - 1'b1);
        o_ctl.last       = i_eos;
        o_slot           = SLOT_W'(w_slot_cur);
        o_len            = w_len;

        n_slot = r_slot;
        if (w_accept) begin
            if (i_eos) begin
                n_slot = (w_slot_inc >= w_len) ? '0 : SLOT_W'(w_slot_inc);
            end else begin
                n_slot = SLOT_W'(w_slot_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= WINDOW_LENGTH_RST;
            r_trailing <= TRAILING_MODE_RST;
            r_slot     <= '0;
        end else begin
            r_slot <= n_slot;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_WINDOW_LENGTH: begin
                        r_win_len <= i_cfg_wdata;
                    end
                    CFG_TRAILING_MODE: begin
                        r_trailing <= i_cfg_wdata[0];
                    end
                    default: begin
                        r_win_len <= r_win_len;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pbtm_median.sv =====
// Lower-median selector over one beam's history row, by parallel ranking.
// Standalone; instantiated twice by the back end.
`default_nettype none

module pbtm_median #(
    parameter int WINDOW_MAX  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic [WINDOW_MAX*SAMPLE_BITS-1:0] i_vals,
    input  wire logic [LEN_W-1:0]                  i_len,
    output logic      [SAMPLE_BITS-1:0]            o_median
);

    logic [SAMPLE_BITS-1:0] w_v    [WINDOW_MAX];
    logic                   w_used [WINDOW_MAX];
    logic [LEN_W-1:0]       w_rank [WINDOW_MAX];
    logic [LEN_W-1:0]       w_k;

    // Each used value's rank counts the used values that sort ahead of it;
    // equal values are ordered by slot so that every rank is unique.
    always_comb begin
        w_k      = (i_len - 1'b1) >> 1;
        o_median = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_v[i]    = i_vals[i*SAMPLE_BITS +: SAMPLE_BITS];
            w_used[i] = LEN_W'(i) < i_len;
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < WINDOW_MAX; j++) begin
                if (w_used[j] && ((w_v[j] < w_v[i]) || ((w_v[j] == w_v[i]) && (j < i)))) begin
                    w_rank[i] = w_rank[i] + 1'b1;
                end
            end
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (w_used[i] && (w_rank[i] == w_k)) begin
                o_median = o_median | w_v[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pbtm_back.sv =====
// Back end: history memory with clearing pass, row update with forwarding,
// and median selection. Depends on pbtm_pkg and pbtm_median.
`default_nettype none

module pbtm_back #(
    parameter int WINDOW_MAX  = 8,
    parameter int MAX_BEAMS   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int SLOT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int LEN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_avail,
    input  wire pbtm_pkg::t_item_ctl           i_ctl,
    input  wire logic [SLOT_W-1:0]             i_slot,
    input  wire logic [LEN_W-1:0]              i_len,
    input  wire logic [SAMPLE_BITS-1:0]        i_range,
    input  wire logic [SAMPLE_BITS-1:0]        i_inten,
    input  wire logic [pbtm_pkg::CNT_W-1:0]    i_out_count,
    output pbtm_pkg::t_back_stat               o_stat,
    output logic                               o_out_push,
    output pbtm_pkg::t_result                  o_out_data
);

    import pbtm_pkg::*;

    localparam int ADDR_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int HALF_W = WINDOW_MAX * SAMPLE_BITS;
    localparam int ROW_W  = 2 * HALF_W;
    localparam int OCC_W  = CNT_W + 1;

    logic [ROW_W-1:0]       r_mem [MAX_BEAMS];
    logic [ROW_W-1:0]       r_rd_row;

    logic                   r_clearing;
    logic [ADDR_W-1:0]      r_clr_addr;

    logic                   r_b_vld;
    t_item_ctl              r_b_ctl;
    logic [SLOT_W-1:0]      r_b_slot;
    logic [LEN_W-1:0]       r_b_len;
    logic [SAMPLE_BITS-1:0] r_b_rng;
    logic [SAMPLE_BITS-1:0] r_b_int;
    logic [ADDR_W-1:0]      r_b_addr;

    logic                   r_fwd_vld;
    logic [ADDR_W-1:0]      r_fwd_addr;
    logic [ROW_W-1:0]       r_fwd_row;

    logic                   r_c_vld;
    t_item_ctl              r_c_ctl;
    logic [LEN_W-1:0]       r_c_len;
    logic [ROW_W-1:0]       r_c_row;

    logic [OCC_W-1:0]       w_occ;
    logic                   w_pop;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_b_wr;
    logic [ROW_W-1:0]       w_base;
    logic [ROW_W-1:0]       w_merged;
    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_addr;
    logic [ROW_W-1:0]       w_mem_wdata;
    logic [SAMPLE_BITS-1:0] w_med_rng;
    logic [SAMPLE_BITS-1:0] w_med_int;

    // Results in flight plus results queued never exceed the result queue.
    assign w_occ = OCC_W'(i_out_count) + OCC_W'(r_b_vld && r_b_ctl.emit) + OCC_W'(r_c_vld);
    assign w_pop = i_cmd_avail && !r_clearing && (w_occ < OCC_W'(QUEUE_DEPTH));
    assign w_rd_addr = ADDR_W'(i_ctl.beam_index);

    assign w_b_wr = r_b_vld && r_b_ctl.in_range;

    // The row read alongside the previous write misses that write; take it
    // from the forwarding register instead.
    assign w_base = (r_fwd_vld && (r_fwd_addr == r_b_addr)) ? r_fwd_row : r_rd_row;

    always_comb begin
        w_merged = w_base;
        for (int s = 0; s < WINDOW_MAX; s++) begin
            if (w_b_wr && (SLOT_W'(s) == r_b_slot)) begin
                w_merged[s*SAMPLE_BITS +: SAMPLE_BITS]          = r_b_rng;
                w_merged[HALF_W + s*SAMPLE_BITS +: SAMPLE_BITS] = r_b_int;
            end
        end
    end

    assign w_mem_we    = r_clearing || w_b_wr;
    assign w_mem_addr  = r_clearing ? r_clr_addr : r_b_addr;
    assign w_mem_wdata = r_clearing ? '0 : w_merged;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd_row <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_b_vld    <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_c_vld    <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == ADDR_W'(MAX_BEAMS - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            r_b_vld   <= w_pop;
            r_fwd_vld <= w_b_wr;
            r_c_vld   <= r_b_vld && r_b_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_b_ctl  <= i_ctl;
            r_b_slot <= i_slot;
            r_b_len  <= i_len;
            r_b_rng  <= i_range;
            r_b_int  <= i_inten;
            r_b_addr <= w_rd_addr;
        end
        r_fwd_addr <= r_b_addr;
        r_fwd_row  <= w_merged;
        r_c_ctl    <= r_b_ctl;
        r_c_len    <= r_b_len;
        r_c_row    <= w_merged;
    end

    pbtm_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_W       (LEN_W)
    ) u_med_rng (
        .i_vals   (r_c_row[HALF_W-1:0]),
        .i_len    (r_c_len),
        .o_median (w_med_rng)
    );

    pbtm_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_W       (LEN_W)
    ) u_med_int (
        .i_vals   (r_c_row[ROW_W-1:HALF_W]),
        .i_len    (r_c_len),
        .o_median (w_med_int)
    );

    always_comb begin
        o_out_push                  = r_c_vld;
        o_out_data.out_beam_index   = r_c_ctl.beam_index;
        o_out_data.last_of_scan     = r_c_ctl.last;
        o_out_data.median_range     = r_c_ctl.in_range ? FIELD_W'(w_med_rng) : '0;
        o_out_data.median_intensity = r_c_ctl.in_range ? FIELD_W'(w_med_int) : '0;
        o_stat.clearing             = r_clearing;
        o_stat.cmd_pop              = w_pop;
    end

endmodule

`default_nettype wire

// ===== rtl/core/per_beam_temporal_median_core.sv =====
// Top level of the per-beam temporal median core: front end, command queue,
// back end and result queue. Depends on pbtm_pkg, pbtm_front, pbtm_fifo, pbtm_back.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         tvalid / tready           tdata: beam, range, intensity; tlast: end of scan
//  m_axis    out        tvalid / tready           tdata: beam, medians; tlast: last of scan
//  cfg       in         write enable, no wait     addr: register index; wdata: value
//
// Sustained rate is one word per cycle in and one result per cycle out while neither
// side stalls and the queues have room. A word enters the command queue when it is
// accepted, is then read from the history into the B-stage registers, has its row
// updated and written back as it moves into the C-stage registers, and enters the
// result queue with its medians, from which it is offered on the master side. The
// history is one row per beam holding all window slots, so one memory read and at
// most one write serve each word.
// After reset a clearing pass zeroes the history, one row per cycle, through all
// MAX_BEAMS rows; no word is accepted during that time.
// Either side may stall on its own: the command queue holds accepted words and
// the result queue holds finished results.
`default_nettype none

module per_beam_temporal_median_core #(
    parameter int WINDOW_MAX  = 8,
    parameter int MAX_BEAMS   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [pbtm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [pbtm_pkg::CFG_W-1:0]      i_cfg_wdata,
    // Sample stream.
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [9:0] beam_index, [25:10] range_sample, [41:26] intensity_sample, rest zero.
    input  wire logic [pbtm_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                            i_s_axis_tlast,
    // Median stream.
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [9:0] out_beam_index, [25:10] median_range, [41:26] median_intensity, rest zero.
    output logic      [pbtm_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    import pbtm_pkg::*;

    `include "per_beam_temporal_median_core_macros.svh"

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMD_W  = 2 * SAMPLE_BITS + SLOT_W + LEN_W + $bits(t_item_ctl);
    localparam int RES_W  = $bits(t_result);

    // Front end to command queue.
    logic                   w_push;
    t_item_ctl              w_ctl_in;
    logic [SLOT_W-1:0]      w_slot_in;
    logic [LEN_W-1:0]       w_len_in;
    logic [SAMPLE_BITS-1:0] w_rng_in;
    logic [SAMPLE_BITS-1:0] w_int_in;
    logic [CMD_W-1:0]       w_cmd_in;
    logic [CMD_W-1:0]       w_cmd_out;
    logic [CNT_W-1:0]       w_cmd_count;
    logic                   w_hold;

    // Command queue to back end.
    t_item_ctl              w_ctl_out;
    logic [SLOT_W-1:0]      w_slot_out;
    logic [LEN_W-1:0]       w_len_out;
    logic [SAMPLE_BITS-1:0] w_rng_out;
    logic [SAMPLE_BITS-1:0] w_int_out;
    t_back_stat             w_stat;

    // Back end to result queue.
    logic                   w_out_push;
    t_result                w_res_in;
    t_result                w_res_out;
    logic [CNT_W-1:0]       w_out_count;
    logic                   w_out_pop;

    // Samples are kept at SAMPLE_BITS in the history.
    assign w_rng_in = SAMPLE_BITS'(i_s_axis_tdata[25:10]);
    assign w_int_in = SAMPLE_BITS'(i_s_axis_tdata[41:26]);

    // No word is taken while the history is cleared or the queue is full.
    assign w_hold = w_stat.clearing || (w_cmd_count == CNT_W'(QUEUE_DEPTH));

    pbtm_front #(
        .WINDOW_MAX (WINDOW_MAX),
        .MAX_BEAMS  (MAX_BEAMS),
        .SLOT_W     (SLOT_W),
        .LEN_W      (LEN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_hold      (w_hold),
        .i_beam      (i_s_axis_tdata[BEAM_W-1:0]),
        .i_eos       (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .o_push      (w_push),
        .o_ctl       (w_ctl_in),
        .o_slot      (w_slot_in),
        .o_len       (w_len_in)
    );

    assign w_cmd_in = {w_rng_in, w_int_in, w_slot_in, w_len_in, w_ctl_in};

    pbtm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_stat.cmd_pop),
        .o_data  (w_cmd_out),
        .o_count (w_cmd_count)
    );

    assign {w_rng_out, w_int_out, w_slot_out, w_len_out, w_ctl_out} = w_cmd_out;

    pbtm_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .MAX_BEAMS   (MAX_BEAMS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SLOT_W      (SLOT_W),
        .LEN_W       (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (w_cmd_count != '0),
        .i_ctl       (w_ctl_out),
        .i_slot      (w_slot_out),
        .i_len       (w_len_out),
        .i_range     (w_rng_out),
        .i_inten     (w_int_out),
        .i_out_count (w_out_count),
        .o_stat      (w_stat),
        .o_out_push  (w_out_push),
        .o_out_data  (w_res_in)
    );

    // The back end reserves a result slot before it issues a word, so the
    // result queue never overflows.
    pbtm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_res_in),
        .i_pop   (w_out_pop),
        .o_data  (w_res_out),
        .o_count (w_out_count)
    );

    assign o_m_axis_tvalid = (w_out_count != '0);
    assign w_out_pop       = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = {(TDATA_W - 2 * FIELD_W - BEAM_W)'(0),
                              w_res_out.median_intensity,
                              w_res_out.median_range,
                              w_res_out.out_beam_index};
    assign o_m_axis_tlast  = w_res_out.last_of_scan;

    // Assertions on the queue credit scheme and the clearing pass.
    `PBTM_ASSERT_ALWAYS(a_out_q_bound, i_clk, i_rst_n, w_out_count <= CNT_W'(QUEUE_DEPTH), "result queue overflow")
    `PBTM_ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, w_stat.cmd_pop, w_cmd_count != '0, "command popped from empty queue")
    `PBTM_ASSERT_IMPLIES(a_clear_quiet, i_clk, i_rst_n, w_stat.clearing, !o_s_axis_tready && (w_out_count == '0), "activity during clearing pass")
    `PBTM_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, !w_stat.clearing, !w_stat.clearing, "clearing pass restarted")

endmodule

`default_nettype wire

// ===== sim/pbtm_median_checker.sv =====
// Scoreboard for the per-beam temporal median core: tracks per-beam histories,
// predicts each median word and compares it with the output stream.
// Depends on pbtm_pkg for the register indexes, widths and the result layout.
`default_nettype none

module pbtm_median_checker #(
    parameter int WINDOW_MAX = 8,
    parameter int MAX_BEAMS  = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pbtm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [pbtm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           i_s_axis_tready,
    input  wire logic [pbtm_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic                           i_s_axis_tlast,
    input  wire logic                           i_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [pbtm_pkg::TDATA_W-1:0]   i_m_axis_tdata,
    input  wire logic                           i_m_axis_tlast,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pbtm_pkg::*;

    localparam int RANGE_LSB = BEAM_W;
    localparam int INTEN_LSB = BEAM_W + FIELD_W;
    localparam int MAX_SHOWN = 100;

    logic [FIELD_W-1:0] range_hist     [0:WINDOW_MAX-1][0:MAX_BEAMS-1];
    logic [FIELD_W-1:0] intensity_hist [0:WINDOW_MAX-1][0:MAX_BEAMS-1];
    logic [CFG_W-1:0]   win_len_reg;
    logic               trailing_reg;
    int                 slot;
    int                 fail_total;
    t_result            pending_medians[$];

    initial begin
        fail_total = 0;
    end

    task automatic flag_mismatch(input string msg);
        if (fail_total < MAX_SHOWN) begin
            $display("MISMATCH @%0t ns: %s", $realtime, msg);
        end
        fail_total++;
    endtask

    // A zero window behaves as one scan, anything above the history depth is capped.
    function automatic int window_scans();
        int n;
        n = int'(win_len_reg);
        if (n == 0) n = 1;
        if (n > WINDOW_MAX) n = WINDOW_MAX;
        return n;
    endfunction

    // Lower median: ascending sort, pick 1-based position ceil(n/2).
    function automatic logic [FIELD_W-1:0] window_median(input bit of_range, input int beam,
                                                         input int n);
        logic [FIELD_W-1:0] vals [0:WINDOW_MAX-1];
        logic [FIELD_W-1:0] x;
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            vals[i] = of_range ? range_hist[i][beam] : intensity_hist[i][beam];
        end
        for (i = 1; i < n; i++) begin
            x = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > x) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = x;
        end
        return vals[(n - 1) / 2];
    endfunction

    task automatic absorb_sample(input logic [TDATA_W-1:0] d, input logic eos);
        int      n;
        int      beam;
        bit      due;
        bit      stored;
        t_result r;
        n    = window_scans();
        beam = int'(d[BEAM_W-1:0]);
        // The slot can sit past the window after the window was shortened.
        if (slot >= n) slot = 0;
        stored = (beam < MAX_BEAMS);
        if (stored) begin
            range_hist[slot][beam]     = d[RANGE_LSB +: FIELD_W];
            intensity_hist[slot][beam] = d[INTEN_LSB +: FIELD_W];
        end
        due = trailing_reg || (slot == n - 1);
        r = '0;
        r.out_beam_index = BEAM_W'(beam);
        r.last_of_scan   = eos;
        if (due && stored) begin
            r.median_range     = window_median(1'b1, beam, n);
            r.median_intensity = window_median(1'b0, beam, n);
        end
        if (eos) begin
            slot++;
            if (slot >= n) slot = 0;
        end
        if (due) pending_medians.push_back(r);
    endtask

    task automatic compare_median(input logic [TDATA_W-1:0] d, input logic last);
        t_result want;
        if (pending_medians.size() == 0) begin
            flag_mismatch($sformatf("median word with nothing expected, beam %0d",
                                    d[BEAM_W-1:0]));
        end else begin
            want = pending_medians.pop_front();
            if (d[BEAM_W-1:0] !== want.out_beam_index)
                flag_mismatch($sformatf("beam index got %0d want %0d",
                                        d[BEAM_W-1:0], want.out_beam_index));
            if (d[RANGE_LSB +: FIELD_W] !== want.median_range)
                flag_mismatch($sformatf("beam %0d range median got %h want %h",
                                        want.out_beam_index, d[RANGE_LSB +: FIELD_W],
                                        want.median_range));
            if (d[INTEN_LSB +: FIELD_W] !== want.median_intensity)
                flag_mismatch($sformatf("beam %0d intensity median got %h want %h",
                                        want.out_beam_index, d[INTEN_LSB +: FIELD_W],
                                        want.median_intensity));
            if (last !== want.last_of_scan)
                flag_mismatch($sformatf("beam %0d last flag got %b want %b",
                                        want.out_beam_index, last, want.last_of_scan));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < WINDOW_MAX; s++) begin
                for (int b = 0; b < MAX_BEAMS; b++) begin
                    range_hist[s][b]     = '0;
                    intensity_hist[s][b] = '0;
                end
            end
            win_len_reg  = WINDOW_LENGTH_RST;
            trailing_reg = TRAILING_MODE_RST;
            slot         = 0;
            pending_medians.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_WINDOW_LENGTH: win_len_reg  = i_cfg_wdata;
                    CFG_TRAILING_MODE: trailing_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) absorb_sample(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) compare_median(i_m_axis_tdata, i_m_axis_tlast);
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_medians.size();
    end

endmodule

`default_nettype wire

// ===== sim/per_beam_temporal_median_core_tb.sv =====
// Testbench top for the per-beam temporal median core: clock, reset, sample
// stimulus, register writes and back-pressure. Depends on pbtm_pkg, the core
// and pbtm_median_checker, which predicts and compares every median word.
`default_nettype none

module per_beam_temporal_median_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbtm_pkg::*;

    localparam int WINDOW_MAX   = 8;
    localparam int MAX_BEAMS    = 1024;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 115;
    // Pipeline depth plus slack, so a word that yields no median is done.
    localparam int DRAIN_CYCLES = 20;
    // Covers the clearing pass and about a thousand words under heavy idling,
    // all taken many times over.
    localparam int CYCLE_LIMIT  = 300000;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr      = '0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                 i_s_axis_tlast  = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct    = 0;
    int stall_pct   = 0;

    per_beam_temporal_median_core #(
        .WINDOW_MAX (WINDOW_MAX),
        .MAX_BEAMS  (MAX_BEAMS),
        .SAMPLE_BITS(FIELD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    pbtm_median_checker #(
        .WINDOW_MAX(WINDOW_MAX),
        .MAX_BEAMS (MAX_BEAMS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tlast (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // The receiver decides afresh every cycle whether it takes a median word.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: a hung handshake or a lost median word ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sample levels lean toward the extremes and toward tiny values, so that
    // ties inside a window are common.
    function automatic logic [FIELD_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIELD_W'($urandom_range(0, 7));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Presents one sample word, after a random idle gap, and returns at the
    // edge where it was taken. Valid stays high into the next word when no gap
    // follows, so it is never lowered and raised in the same step.
    task automatic push_word(input logic [BEAM_W-1:0] beam, input logic [FIELD_W-1:0] rng,
                             input logic [FIELD_W-1:0] inten, input logic eos);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(TDATA_W - BEAM_W - 2 * FIELD_W){1'b0}}, inten, rng, beam};
        i_s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stops the sample stream and waits until every predicted median word has
    // come out, then lets the pipeline finish words that yield no median.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles; only called when idle.
    task automatic apply_settings(input logic [CFG_W-1:0] win_len, input logic trailing);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WINDOW_LENGTH;
        i_cfg_wdata <= win_len;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TRAILING_MODE;
        i_cfg_wdata <= {{(CFG_W - 1){1'b0}}, trailing};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0]  phase_len  [0:PHASES-1];
        logic              phase_tr   [0:PHASES-1];
        int                sent;
        int                span;
        int                base;
        logic [BEAM_W-1:0] beam;

        // Window settings per random phase, the extremes among them.
        phase_len = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
        phase_tr  = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1,  1'b1, 1'b0, 1'b1};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, a window of three in batch mode. Beams 0 and
        // 1023 with extreme samples; the third scan brings out two medians.
        idle_pct  = 30;
        stall_pct = 30;
        push_word(10'd0,    16'hFFFF, 16'h0000, 1'b0);
        push_word(10'd1023, 16'h0000, 16'hFFFF, 1'b1);
        push_word(10'd0,    16'h8000, 16'h7FFF, 1'b0);
        push_word(10'd1023, 16'h5555, 16'hAAAA, 1'b1);
        push_word(10'd0,    16'h0001, 16'hFFFE, 1'b0);
        push_word(10'd1023, 16'hAAAA, 16'h5555, 1'b1);
        settle();

        // A zero window acts as a window of one: each median is the sample itself.
        apply_settings(4'd0, 1'b1);
        push_word(10'h155, 16'h1234, 16'hFEDC, 1'b0);
        push_word(10'h2AA, 16'hFFFF, 16'h0000, 1'b1);
        push_word(10'h155, 16'h0000, 16'hFFFF, 1'b1);
        settle();

        // A window above the history depth is capped at eight; the slot walks
        // up to six, with medians over partly zero history.
        apply_settings(4'd15, 1'b1);
        repeat (6) push_word(10'd1023, pick_level(), pick_level(), 1'b1);
        settle();

        // Shrinking the window to two leaves the slot beyond it, so it restarts.
        apply_settings(4'd2, 1'b0);
        repeat (3) push_word(10'd1023, pick_level(), pick_level(), 1'b1);
        settle();

        // Random phases: mostly whole scans over a fixed small set of beams so
        // that histories fill and medians mean something, with some noise words
        // at any beam and with a random end-of-scan flag.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            apply_settings(phase_len[ph], phase_tr[ph]);
            span = $urandom_range(1, 5);
            base = (ph == 3) ? (MAX_BEAMS - span) : $urandom_range(0, MAX_BEAMS - span);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 99) < 12) begin
                    beam = BEAM_W'($urandom);
                    push_word(beam, pick_level(), pick_level(), 1'($urandom));
                    sent++;
                end else begin
                    for (int b = 0; b < span; b++) begin
                        beam = BEAM_W'(base + b);
                        push_word(beam, pick_level(), pick_level(), b == span - 1);
                        sent++;
                    end
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== per_beam_temporal_median_core.f =====
+incdir+rtl/core
rtl/core/pbtm_pkg.sv
rtl/core/pbtm_fifo.sv
rtl/core/pbtm_front.sv
rtl/core/pbtm_median.sv
rtl/core/pbtm_back.sv
rtl/core/per_beam_temporal_median_core.sv
sim/pbtm_median_checker.sv
sim/per_beam_temporal_median_core_tb.sv
